[sv/arsc_pkg.sv]
// shared types, constants and angle helpers for the arm reach safety check
package arsc_pkg;

    localparam int ANGLE_W    = 9;
    localparam int WANGLE_W   = 10;
    localparam int LEN_W      = 8;
    localparam int HALF_W     = 10;
    localparam int FLOOR_W    = 11;
    localparam int COORD_W    = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 11;
    localparam int QIDX_W     = 7;
    localparam int QSINE_W    = 17;
    localparam int NUM_LANES  = 6;
    localparam int NUM_ANGLES = 3;

    typedef logic [ANGLE_W-1:0]  angle_t;
    typedef logic [WANGLE_W-1:0] wangle_t;
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    localparam wangle_t DEG_90   = 10'd90;
    localparam wangle_t DEG_180  = 10'd180;
    localparam wangle_t DEG_270  = 10'd270;
    localparam wangle_t DEG_360  = 10'd360;
    localparam wangle_t OFF_PHIW = 10'd990;

    localparam cfg_idx_t REG_SHOULDER_LEN = 3'd0;
    localparam cfg_idx_t REG_ELBOW_LEN    = 3'd1;
    localparam cfg_idx_t REG_WRIST_LEN    = 3'd2;
    localparam cfg_idx_t REG_BOX_HALF_W   = 3'd3;
    localparam cfg_idx_t REG_BOX_FLOOR    = 3'd4;

    localparam logic [LEN_W-1:0]          RST_SHOULDER_LEN = 8'd53;
    localparam logic [LEN_W-1:0]          RST_ELBOW_LEN    = 8'd38;
    localparam logic [LEN_W-1:0]          RST_WRIST_LEN    = 8'd47;
    localparam logic [HALF_W-1:0]         RST_BOX_HALF_W   = 10'd40;
    localparam logic signed [FLOOR_W-1:0] RST_BOX_FLOOR    = -11'sd24;

    // angle slots and trig lanes
    localparam int ANG_T1   = 0;
    localparam int ANG_PHI3 = 1;
    localparam int ANG_PHIW = 2;

    localparam int LANE_SIN_T1   = 0;
    localparam int LANE_COS_T1   = 1;
    localparam int LANE_SIN_PHI3 = 2;
    localparam int LANE_COS_PHI3 = 3;
    localparam int LANE_SIN_PHIW = 4;
    localparam int LANE_COS_PHIW = 5;

    typedef struct packed {
        logic [LEN_W-1:0] shoulder;
        logic [LEN_W-1:0] elbow;
        logic [LEN_W-1:0] wrist;
    } links_t;

    typedef struct packed {
        logic               neg;
        logic [QIDX_W-1:0]  idx;
    } fold_t;

    // round(65536 * sin(k deg)), k = 0..90
    localparam logic [QSINE_W-1:0] QUARTER_SINE [91] = '{
        17'd0, 17'd1144, 17'd2287, 17'd3430, 17'd4572, 17'd5712, 17'd6850, 17'd7987,
        17'd9121, 17'd10252, 17'd11380, 17'd12505, 17'd13626, 17'd14742, 17'd15855,
        17'd16962, 17'd18064, 17'd19161, 17'd20252, 17'd21336, 17'd22415, 17'd23486,
        17'd24550, 17'd25607, 17'd26656, 17'd27697, 17'd28729, 17'd29753, 17'd30767,
        17'd31772, 17'd32768, 17'd33754, 17'd34729, 17'd35693, 17'd36647, 17'd37590,
        17'd38521, 17'd39441, 17'd40348, 17'd41243, 17'd42126, 17'd42995, 17'd43852,
        17'd44695, 17'd45525, 17'd46341, 17'd47143, 17'd47930, 17'd48703, 17'd49461,
        17'd50203, 17'd50931, 17'd51643, 17'd52339, 17'd53020, 17'd53684, 17'd54332,
        17'd54963, 17'd55578, 17'd56175, 17'd56756, 17'd57319, 17'd57865, 17'd58393,
        17'd58903, 17'd59396, 17'd59870, 17'd60326, 17'd60764, 17'd61183, 17'd61584,
        17'd61966, 17'd62328, 17'd62672, 17'd62997, 17'd63303, 17'd63589, 17'd63856,
        17'd64104, 17'd64332, 17'd64540, 17'd64729, 17'd64898, 17'd65048, 17'd65177,
        17'd65287, 17'd65376, 17'd65446, 17'd65496, 17'd65526, 17'd65536
    };

    function automatic wangle_t mod360_step(input wangle_t a);
        return (a >= DEG_360) ? wangle_t'(a - DEG_360) : a;
    endfunction

    function automatic fold_t sine_fold(input angle_t d);
        fold_t   f;
        wangle_t dw;
        wangle_t t;
        dw = {1'b0, d};
        if (dw <= DEG_90)
        begin
            f.neg = 1'b0;
            t     = dw;
        end
        else if (dw <= DEG_180)
        begin
            f.neg = 1'b0;
            t     = wangle_t'(DEG_180 - dw);
        end
        else if (dw <= DEG_270)
        begin
            f.neg = 1'b1;
            t     = wangle_t'(dw - DEG_180);
        end
        else
        begin
            f.neg = 1'b1;
            t     = wangle_t'(DEG_360 - dw);
        end
        f.idx = t[QIDX_W-1:0];
        return f;
    endfunction

endpackage

[sv/arsc_angle.sv]
// three-stage joint angle reduction and chain angle computation
module arsc_angle
    import arsc_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_vld,
    input  angle_t                      shoulder_angle,
    input  angle_t                      elbow_angle,
    input  angle_t                      wrist_angle,
    output logic                        out_vld,
    output logic [NUM_ANGLES-1:0][ANGLE_W-1:0] angles
);

    logic    vld1_reg, vld2_reg, vld3_reg;
    angle_t  t1_s1_reg, t2_s1_reg, t3_s1_reg;
    angle_t  t1_s2_reg, t3_s2_reg, phi3_s2_reg;
    angle_t  t1_s3_reg, phi3_s3_reg, phiw_s3_reg;
    wangle_t t1_next, t2_next, t3_next;
    wangle_t phi3_sum, phi3_next;
    wangle_t phiw_diff, phiw_next;

    assign t1_next   = mod360_step({1'b0, shoulder_angle});
    assign t2_next   = mod360_step({1'b0, elbow_angle});
    assign t3_next   = mod360_step({1'b0, wrist_angle});

    // phi3 = t1 + t2 - 90
    assign phi3_sum  = wangle_t'({1'b0, t1_s1_reg} + {1'b0, t2_s1_reg} + DEG_270);
    assign phi3_next = mod360_step(mod360_step(phi3_sum));

    // wrist chain angle = 270 - t3 - phi3
    assign phiw_diff = wangle_t'(OFF_PHIW - {1'b0, t3_s2_reg} - {1'b0, phi3_s2_reg});
    assign phiw_next = mod360_step(mod360_step(phiw_diff));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld1_reg <= 1'b0;
            vld2_reg <= 1'b0;
            vld3_reg <= 1'b0;
        end
        else
        begin
            vld1_reg <= in_vld;
            vld2_reg <= vld1_reg;
            vld3_reg <= vld2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        t1_s1_reg   <= t1_next[ANGLE_W-1:0];
        t2_s1_reg   <= t2_next[ANGLE_W-1:0];
        t3_s1_reg   <= t3_next[ANGLE_W-1:0];
        t1_s2_reg   <= t1_s1_reg;
        t3_s2_reg   <= t3_s1_reg;
        phi3_s2_reg <= phi3_next[ANGLE_W-1:0];
        t1_s3_reg   <= t1_s2_reg;
        phi3_s3_reg <= phi3_s2_reg;
        phiw_s3_reg <= phiw_next[ANGLE_W-1:0];
    end

    assign out_vld          = vld3_reg;
    assign angles[ANG_T1]   = t1_s3_reg;
    assign angles[ANG_PHI3] = phi3_s3_reg;
    assign angles[ANG_PHIW] = phiw_s3_reg;

endmodule

[sv/arsc_trig.sv]
// registered sine and cosine table lookup, six lanes
module arsc_trig
    import arsc_pkg::*;
#(
    parameter int SINE_FRAC_BITS = 14
)
(
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     in_vld,
    input  logic [NUM_ANGLES-1:0][ANGLE_W-1:0]       angles,
    output logic                                     out_vld,
    output logic [NUM_LANES-1:0][SINE_FRAC_BITS+1:0] sines
);

    localparam int SW   = SINE_FRAC_BITS + 2;
    localparam int TRIM = QSINE_W - 1 - SINE_FRAC_BITS;

    logic                           vld_reg;
    logic [NUM_LANES-1:0][SW-1:0]   sine_reg;
    logic [NUM_LANES-1:0][SW-1:0]   sine_next;

    for (genvar i = 0; i < NUM_LANES; i++)
    begin : g_lane
        localparam int SRC    = i / 2;
        localparam bit IS_COS = (i % 2) == 1;

        wangle_t              shifted;
        angle_t               lane_angle;
        fold_t                f;
        logic [QSINE_W-1:0]   q;
        logic [QSINE_W:0]     t;
        logic [QSINE_W:0]     mag;
        logic [SW-1:0]        mag_ext;

        // cosine as sine of angle plus 90
        assign shifted    = IS_COS ? mod360_step(wangle_t'({1'b0, angles[SRC]} + DEG_90))
                                   : {1'b0, angles[SRC]};
        assign lane_angle = shifted[ANGLE_W-1:0];
        assign f          = sine_fold(lane_angle);
        assign q          = QUARTER_SINE[f.idx];
        assign t          = {q, 1'b0} >> TRIM;
        assign mag        = (t + 1'b1) >> 1;
        assign mag_ext    = {1'b0, mag[SW-2:0]};
        assign sine_next[i] = f.neg ? SW'(-mag_ext) : mag_ext;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= in_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        sine_reg <= sine_next;
    end

    assign out_vld = vld_reg;
    assign sines   = sine_reg;

endmodule

[sv/arsc_kin.sv]
// link length multiply and position sum, two stages
module arsc_kin
    import arsc_pkg::*;
#(
    parameter int SINE_FRAC_BITS = 14
)
(
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      in_vld,
    input  logic [NUM_LANES-1:0][SINE_FRAC_BITS+1:0]  sines,
    input  links_t                                    links,
    output logic                                      out_vld,
    output logic signed [SINE_FRAC_BITS+12:0]         elbow_px,
    output logic signed [SINE_FRAC_BITS+12:0]         elbow_py,
    output logic signed [SINE_FRAC_BITS+12:0]         hand_px,
    output logic signed [SINE_FRAC_BITS+12:0]         hand_py
);

    localparam int SW = SINE_FRAC_BITS + 2;
    localparam int MW = SW + LEN_W + 1;
    localparam int PW = MW + 2;

    logic                          vld_a_reg, vld_b_reg;
    logic [NUM_LANES-1:0][MW-1:0]  prod_reg;
    logic [NUM_LANES-1:0][MW-1:0]  prod_next;
    logic signed [PW-1:0]          pe [NUM_LANES];
    logic signed [PW-1:0]          ex_reg, ey_reg, hx_reg, hy_reg;
    logic signed [PW-1:0]          ex_next, ey_next, hx_next, hy_next;

    for (genvar i = 0; i < NUM_LANES; i++)
    begin : g_mul
        localparam int SRC = i / 2;
        logic [LEN_W-1:0] len;

        if (SRC == ANG_T1)
        begin : g_s
            assign len = links.shoulder;
        end
        else if (SRC == ANG_PHI3)
        begin : g_e
            assign len = links.elbow;
        end
        else
        begin : g_w
            assign len = links.wrist;
        end

        assign prod_next[i] = MW'($signed({1'b0, len})) * MW'($signed(sines[i]));
        assign pe[i]        = PW'($signed(prod_reg[i]));
    end

    assign ex_next = -pe[LANE_COS_T1];
    assign ey_next = pe[LANE_SIN_T1];
    assign hx_next = -pe[LANE_COS_T1] - pe[LANE_SIN_PHI3] - pe[LANE_SIN_PHIW];
    assign hy_next = pe[LANE_SIN_T1] - pe[LANE_COS_PHI3] - pe[LANE_COS_PHIW];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_a_reg <= 1'b0;
            vld_b_reg <= 1'b0;
        end
        else
        begin
            vld_a_reg <= in_vld;
            vld_b_reg <= vld_a_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        ex_reg   <= ex_next;
        ey_reg   <= ey_next;
        hx_reg   <= hx_next;
        hy_reg   <= hy_next;
    end

    assign out_vld  = vld_b_reg;
    assign elbow_px = ex_reg;
    assign elbow_py = ey_reg;
    assign hand_px  = hx_reg;
    assign hand_py  = hy_reg;

endmodule

[sv/arsc_out.sv]
// coordinate rounding, saturation and keep-out test, output register
module arsc_out
    import arsc_pkg::*;
#(
    parameter int SINE_FRAC_BITS  = 14,
    parameter int COORD_FRAC_BITS = 8
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_vld,
    input  logic signed [SINE_FRAC_BITS+12:0] elbow_px,
    input  logic signed [SINE_FRAC_BITS+12:0] elbow_py,
    input  logic signed [SINE_FRAC_BITS+12:0] hand_px,
    input  logic signed [SINE_FRAC_BITS+12:0] hand_py,
    input  logic [HALF_W-1:0]                 box_half_width,
    input  logic signed [FLOOR_W-1:0]         box_floor,
    output logic                              done,
    output logic                              is_safe,
    output logic signed [COORD_W-1:0]         elbow_x,
    output logic signed [COORD_W-1:0]         elbow_y,
    output logic signed [COORD_W-1:0]         hand_x,
    output logic signed [COORD_W-1:0]         hand_y
);

    localparam int PW = SINE_FRAC_BITS + 13;
    localparam int RS = 3 + SINE_FRAC_BITS - COORD_FRAC_BITS;
    localparam int RW = PW + COORD_W + 2;
    localparam int CW = PW + 2;
    localparam logic signed [RW-1:0] HALF_LSB  = RW'(1) <<< (RS - 1);
    localparam logic signed [RW-1:0] COORD_MAX = RW'(2**(COORD_W-1) - 1);
    localparam logic signed [RW-1:0] COORD_MIN = -COORD_MAX - RW'(1);

    function automatic logic [COORD_W-1:0] to_coord(input logic signed [PW-1:0] v);
        logic signed [RW-1:0] w;
        logic signed [RW-1:0] r;
        logic [COORD_W-1:0]   c;
        // half rounds toward +inf
        w = RW'(v) + HALF_LSB;
        r = w >>> RS;
        if (r > COORD_MAX)
        begin
            c = COORD_MAX[COORD_W-1:0];
        end
        else if (r < COORD_MIN)
        begin
            c = COORD_MIN[COORD_W-1:0];
        end
        else
        begin
            c = r[COORD_W-1:0];
        end
        return c;
    endfunction

    logic signed [CW-1:0] lim_w, lim_f, hxe, hye;
    logic                 in_width, in_height, below, safe_next;
    logic                 done_reg, safe_reg;
    logic [COORD_W-1:0]   ex_reg, ey_reg, hx_reg, hy_reg;

    assign lim_w     = CW'($signed({1'b0, box_half_width})) <<< SINE_FRAC_BITS;
    assign lim_f     = CW'(box_floor) <<< SINE_FRAC_BITS;
    assign hxe       = CW'(hand_px);
    assign hye       = CW'(hand_py);
    assign in_width  = (hxe > -lim_w) && (hxe < lim_w);
    assign in_height = (hye > lim_f) && (hye < CW'(0));
    assign below     = hye < lim_f;
    assign safe_next = !((in_width && in_height) || below);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= in_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        safe_reg <= safe_next;
        ex_reg   <= to_coord(elbow_px);
        ey_reg   <= to_coord(elbow_py);
        hx_reg   <= to_coord(hand_px);
        hy_reg   <= to_coord(hand_py);
    end

    assign done    = done_reg;
    assign is_safe = safe_reg;
    assign elbow_x = ex_reg;
    assign elbow_y = ey_reg;
    assign hand_x  = hx_reg;
    assign hand_y  = hy_reg;

endmodule

[sv/arm_reach_safety_check.sv]
// top level of the three-link arm reach and keep-out check
//
// channel   signals                                         transfer when
// input     start, busy, shoulder/elbow/wrist_angle         start && !busy
// result    done, is_safe, elbow_x/y, hand_x/y              done (one cycle)
// config    cfg_valid, cfg_ready, cfg_index, cfg_data       cfg_valid && cfg_ready
//
// one item per cycle, busy stays low
// pipeline stages: 3 angle stages, table read, multiply, sum, round
// asynchronous active-low reset empties the pipeline and loads default registers
// results are never held back by the receiver
module arm_reach_safety_check
    import arsc_pkg::*;
#(
    parameter int SINE_FRAC_BITS  = 14,
    parameter int COORD_FRAC_BITS = 8
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [ANGLE_W-1:0]        shoulder_angle,
    input  logic [ANGLE_W-1:0]        elbow_angle,
    input  logic [ANGLE_W-1:0]        wrist_angle,
    output logic                      done,
    output logic                      is_safe,
    output logic signed [COORD_W-1:0] elbow_x,
    output logic signed [COORD_W-1:0] elbow_y,
    output logic signed [COORD_W-1:0] hand_x,
    output logic signed [COORD_W-1:0] hand_y,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_IDX_W-1:0]      cfg_index,
    input  logic [CFG_DATA_W-1:0]     cfg_data
);

    localparam int SW = SINE_FRAC_BITS + 2;
    localparam int PW = SINE_FRAC_BITS + 13;

    links_t                       links_reg;
    logic [HALF_W-1:0]            half_w_reg;
    logic signed [FLOOR_W-1:0]    floor_reg;
    logic                         in_vld;
    logic                         ang_vld, trig_vld, kin_vld;
    logic [NUM_ANGLES-1:0][ANGLE_W-1:0] angles;
    logic [NUM_LANES-1:0][SW-1:0] sines;
    logic signed [PW-1:0]         ex, ey, hx, hy;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign in_vld    = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            links_reg.shoulder <= RST_SHOULDER_LEN;
            links_reg.elbow    <= RST_ELBOW_LEN;
            links_reg.wrist    <= RST_WRIST_LEN;
            half_w_reg         <= RST_BOX_HALF_W;
            floor_reg          <= RST_BOX_FLOOR;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_SHOULDER_LEN: links_reg.shoulder <= cfg_data[LEN_W-1:0];
                REG_ELBOW_LEN:    links_reg.elbow    <= cfg_data[LEN_W-1:0];
                REG_WRIST_LEN:    links_reg.wrist    <= cfg_data[LEN_W-1:0];
                REG_BOX_HALF_W:   half_w_reg         <= cfg_data[HALF_W-1:0];
                REG_BOX_FLOOR:    floor_reg          <= $signed(cfg_data[FLOOR_W-1:0]);
                default:          ;
            endcase
        end
    end

    arsc_angle u_angle (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_vld         (in_vld),
        .shoulder_angle (shoulder_angle),
        .elbow_angle    (elbow_angle),
        .wrist_angle    (wrist_angle),
        .out_vld        (ang_vld),
        .angles         (angles)
    );

    arsc_trig #(
        .SINE_FRAC_BITS (SINE_FRAC_BITS)
    ) u_trig (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_vld  (ang_vld),
        .angles  (angles),
        .out_vld (trig_vld),
        .sines   (sines)
    );

    arsc_kin #(
        .SINE_FRAC_BITS (SINE_FRAC_BITS)
    ) u_kin (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_vld   (trig_vld),
        .sines    (sines),
        .links    (links_reg),
        .out_vld  (kin_vld),
        .elbow_px (ex),
        .elbow_py (ey),
        .hand_px  (hx),
        .hand_py  (hy)
    );

    arsc_out #(
        .SINE_FRAC_BITS  (SINE_FRAC_BITS),
        .COORD_FRAC_BITS (COORD_FRAC_BITS)
    ) u_out (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_vld         (kin_vld),
        .elbow_px       (ex),
        .elbow_py       (ey),
        .hand_px        (hx),
        .hand_py        (hy),
        .box_half_width (half_w_reg),
        .box_floor      (floor_reg),
        .done           (done),
        .is_safe        (is_safe),
        .elbow_x        (elbow_x),
        .elbow_y        (elbow_y),
        .hand_x         (hand_x),
        .hand_y         (hand_y)
    );

endmodule

[sv/arsc_checker.sv]
// port-level checker for the arm reach safety check, with its bind
module arsc_checker
    import arsc_pkg::*;
(
    input logic                      clk,
    input logic                      rst_n,
    input logic                      start,
    input logic                      busy,
    input logic [ANGLE_W-1:0]        shoulder_angle,
    input logic [ANGLE_W-1:0]        elbow_angle,
    input logic [ANGLE_W-1:0]        wrist_angle,
    input logic                      done,
    input logic                      is_safe,
    input logic signed [COORD_W-1:0] elbow_x,
    input logic signed [COORD_W-1:0] elbow_y,
    input logic signed [COORD_W-1:0] hand_x,
    input logic signed [COORD_W-1:0] hand_y,
    input logic                      cfg_valid,
    input logic                      cfg_ready,
    input logic [CFG_IDX_W-1:0]      cfg_index,
    input logic [CFG_DATA_W-1:0]     cfg_data
);

    // every input transfer gives one result
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##7 done)
        else $error("missing result after input transfer");

    // no result without an input transfer
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        !(start && !busy) |-> ##7 !done)
        else $error("result without input transfer");

    // pipeline never back-pressures either channel
    a_always_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !busy && cfg_ready)
        else $error("busy or cfg_ready stalled");

    // a hand just above zero height and far out in x is reported safe
    a_far_hand_safe: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (hand_y > 16'sd8) && ((hand_x > 16'sd30000) || (hand_x < -16'sd30000)))
        |-> is_safe)
        else $error("far hand flagged unsafe");

endmodule

bind arm_reach_safety_check arsc_checker u_arsc_checker (.*);

[verif/arm_reach_safety_check_tb.sv]
// self-checking testbench for the three-link arm reach and keep-out check
`timescale 1ns / 1ps

module arm_reach_safety_check_tb
    import arsc_pkg::*;
();

    localparam int SINE_FRAC   = 14;
    localparam int COORD_FRAC  = 8;
    localparam int ROUND_SHIFT = 3 + SINE_FRAC - COORD_FRAC;
    localparam int SETTLE_CYC  = 12;
    localparam int GAP_PCT     = 38;

    // round(65536 * sin(k deg)), k = 0..90
    localparam int unsigned DEG_SINE_LUT [91] = '{
        0, 1144, 2287, 3430, 4572, 5712, 6850, 7987, 9121, 10252,
        11380, 12505, 13626, 14742, 15855, 16962, 18064, 19161, 20252, 21336,
        22415, 23486, 24550, 25607, 26656, 27697, 28729, 29753, 30767, 31772,
        32768, 33754, 34729, 35693, 36647, 37590, 38521, 39441, 40348, 41243,
        42126, 42995, 43852, 44695, 45525, 46341, 47143, 47930, 48703, 49461,
        50203, 50931, 51643, 52339, 53020, 53684, 54332, 54963, 55578, 56175,
        56756, 57319, 57865, 58393, 58903, 59396, 59870, 60326, 60764, 61183,
        61584, 61966, 62328, 62672, 62997, 63303, 63589, 63856, 64104, 64332,
        64540, 64729, 64898, 65048, 65177, 65287, 65376, 65446, 65496, 65526,
        65536
    };

    typedef struct packed {
        logic                      safe;
        logic signed [COORD_W-1:0] ex;
        logic signed [COORD_W-1:0] ey;
        logic signed [COORD_W-1:0] hx;
        logic signed [COORD_W-1:0] hy;
    } pose_t;

    logic                      clk;
    logic                      rst_n;
    logic                      start;
    logic                      busy;
    angle_t                    shoulder_angle;
    angle_t                    elbow_angle;
    angle_t                    wrist_angle;
    logic                      done;
    logic                      is_safe;
    logic signed [COORD_W-1:0] elbow_x;
    logic signed [COORD_W-1:0] elbow_y;
    logic signed [COORD_W-1:0] hand_x;
    logic signed [COORD_W-1:0] hand_y;
    logic                      cfg_valid;
    logic                      cfg_ready;
    cfg_idx_t                  cfg_index;
    logic [CFG_DATA_W-1:0]     cfg_data;

    // register shadow
    logic [LEN_W-1:0]          len_shoulder = RST_SHOULDER_LEN;
    logic [LEN_W-1:0]          len_elbow    = RST_ELBOW_LEN;
    logic [LEN_W-1:0]          len_wrist    = RST_WRIST_LEN;
    logic [HALF_W-1:0]         half_width   = RST_BOX_HALF_W;
    logic signed [FLOOR_W-1:0] floor_h      = RST_BOX_FLOOR;

    pose_t pose_q [$];
    int    err_count   = 0;
    int    items_sent  = 0;
    int    poses_seen  = 0;
    int    cfg_phases  = 0;
    bit    gaps_on     = 1'b1;

    arm_reach_safety_check #(
        .SINE_FRAC_BITS  (SINE_FRAC),
        .COORD_FRAC_BITS (COORD_FRAC)
    ) dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .shoulder_angle (shoulder_angle),
        .elbow_angle    (elbow_angle),
        .wrist_angle    (wrist_angle),
        .done           (done),
        .is_safe        (is_safe),
        .elbow_x        (elbow_x),
        .elbow_y        (elbow_y),
        .hand_x         (hand_x),
        .hand_y         (hand_y),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic longint lut_sine(int d);
        int unsigned v;
        int unsigned t;
        v = DEG_SINE_LUT[d];
        t = (v << 1) >> (16 - SINE_FRAC);
        return longint'((t + 1) >> 1);
    endfunction

    function automatic longint sin_deg(int d);
        d = d % 360;
        if (d <= 90)
            return lut_sine(d);
        else if (d <= 180)
            return lut_sine(180 - d);
        else if (d <= 270)
            return -lut_sine(d - 180);
        else
            return -lut_sine(360 - d);
    endfunction

    function automatic longint cos_deg(int d);
        return sin_deg((d % 360) + 90);
    endfunction

    function automatic logic signed [COORD_W-1:0] round_coord(longint v);
        longint r;
        r = (v + (longint'(1) <<< (ROUND_SHIFT - 1))) >>> ROUND_SHIFT;
        if (r > 32767)
            r = 32767;
        if (r < -32768)
            r = -32768;
        return r[COORD_W-1:0];
    endfunction

    function automatic pose_t predict_pose(angle_t a_s, angle_t a_e, angle_t a_w);
        int     t1;
        int     t2;
        int     t3;
        int     phi3;
        int     phiw;
        longint ls;
        longint le;
        longint lw;
        longint ex;
        longint ey;
        longint hx;
        longint hy;
        longint w;
        longint fl;
        logic   in_w;
        logic   in_h;
        logic   below;
        pose_t  p;
        t1   = int'(a_s) % 360;
        t2   = int'(a_e) % 360;
        t3   = int'(a_w) % 360;
        phi3 = (t1 + t2 + 270) % 360;
        phiw = (990 - t3 - phi3) % 360;
        ls   = longint'(len_shoulder);
        le   = longint'(len_elbow);
        lw   = longint'(len_wrist);
        ex   = -ls * cos_deg(t1);
        ey   = ls * sin_deg(t1);
        hx   = ex - le * sin_deg(phi3) - lw * sin_deg(phiw);
        hy   = ey - le * cos_deg(phi3) - lw * cos_deg(phiw);
        w    = longint'(half_width) * (longint'(1) <<< SINE_FRAC);
        fl   = longint'(floor_h) * (longint'(1) <<< SINE_FRAC);
        in_w  = (hx > -w) && (hx < w);
        in_h  = (hy > fl) && (hy < 0);
        below = hy < fl;
        p.safe = !((in_w && in_h) || below);
        p.ex   = round_coord(ex);
        p.ey   = round_coord(ey);
        p.hx   = round_coord(hx);
        p.hy   = round_coord(hy);
        return p;
    endfunction

    task automatic report_mismatch(string msg);
        $display("ERROR %0t: %s", $time, msg);
        err_count++;
    endtask

    task automatic check_field(string name, logic signed [COORD_W-1:0] got,
                               logic signed [COORD_W-1:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
    endtask

    // result checker, item capture and register shadow
    always @(posedge clk)
    begin : monitor
        pose_t want;
        if (done)
        begin
            if (pose_q.size() == 0)
                report_mismatch("result with no item outstanding");
            else
            begin
                want = pose_q.pop_front();
                poses_seen++;
                check_field("is_safe", COORD_W'(is_safe), COORD_W'(want.safe));
                check_field("elbow_x", elbow_x, want.ex);
                check_field("elbow_y", elbow_y, want.ey);
                check_field("hand_x", hand_x, want.hx);
                check_field("hand_y", hand_y, want.hy);
            end
        end
        if (rst_n && start && !busy)
        begin
            pose_q.push_back(predict_pose(shoulder_angle, elbow_angle, wrist_angle));
            items_sent++;
        end
        if (rst_n && cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_SHOULDER_LEN: len_shoulder = cfg_data[LEN_W-1:0];
                REG_ELBOW_LEN:    len_elbow    = cfg_data[LEN_W-1:0];
                REG_WRIST_LEN:    len_wrist    = cfg_data[LEN_W-1:0];
                REG_BOX_HALF_W:   half_width   = cfg_data[HALF_W-1:0];
                REG_BOX_FLOOR:    floor_h      = cfg_data[FLOOR_W-1:0];
                default: ;
            endcase
        end
    end

    task automatic send_angles(angle_t a_s, angle_t a_e, angle_t a_w);
        while (gaps_on && $urandom_range(99) < GAP_PCT)
        begin
            @(negedge clk);
            start <= 1'b0;
        end
        @(negedge clk);
        start          <= 1'b1;
        shoulder_angle <= a_s;
        elbow_angle    <= a_e;
        wrist_angle    <= a_w;
        do
            @(posedge clk);
        while (busy);
    endtask

    task automatic pause_for_results();
        @(negedge clk);
        start <= 1'b0;
        while (pose_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYC) @(posedge clk);
    endtask

    task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_config(int ls, int le, int lw, int hw, int fl);
        pause_for_results();
        write_reg(REG_SHOULDER_LEN, CFG_DATA_W'(ls));
        write_reg(REG_ELBOW_LEN, CFG_DATA_W'(le));
        write_reg(REG_WRIST_LEN, CFG_DATA_W'(lw));
        write_reg(REG_BOX_HALF_W, CFG_DATA_W'(hw));
        write_reg(REG_BOX_FLOOR, CFG_DATA_W'(fl));
        cfg_phases++;
    endtask

    function automatic angle_t rand_angle();
        if ($urandom_range(99) < 88)
            return angle_t'($urandom_range(359));
        return angle_t'($urandom_range(511, 360));
    endfunction

    task automatic send_random_angles(int count);
        repeat (count) send_angles(rand_angle(), rand_angle(), rand_angle());
    endtask

    task automatic test_directed_angles();
        angle_t dir_s [15] = '{0, 359, 90, 180, 270, 360, 511, 1, 179, 271,
                               9'h155, 9'h0aa, 45, 315, 400};
        angle_t dir_e [15] = '{0, 359, 90, 180, 270, 360, 511, 89, 181, 0,
                               9'h0aa, 9'h155, 135, 30, 450};
        angle_t dir_w [15] = '{0, 359, 90, 180, 270, 360, 511, 91, 269, 359,
                               9'h1ff, 9'h000, 225, 60, 500};
        foreach (dir_s[i])
            send_angles(dir_s[i], dir_e[i], dir_w[i]);
    endtask

    task automatic test_keepout_edges();
        // hand straight down from the elbow, elbow on the negative x axis
        set_config(40, 0, 10, 40, -24);
        send_angles(0, 0, 0);
        set_config(40, 0, 10, 41, -24);
        send_angles(0, 0, 0);
        // hand exactly on, just under and just over the floor
        set_config(0, 0, 24, 5, -24);
        send_angles(0, 0, 0);
        set_config(0, 0, 24, 5, -23);
        send_angles(0, 0, 0);
        set_config(0, 0, 24, 5, -25);
        send_angles(0, 0, 0);
    endtask

    task automatic test_register_extremes();
        set_config(0, 0, 0, 0, 0);
        send_random_angles(8);
        set_config(255, 255, 255, 1023, -1024);
        send_random_angles(8);
        set_config(11'h7ff, 11'h700, 11'h6aa, 11'h7ff, 0);
        send_random_angles(8);
        // positive floor
        set_config(53, 38, 47, 600, 1023);
        send_random_angles(8);
        // writes past the last register must change nothing
        pause_for_results();
        for (int i = int'(REG_BOX_FLOOR) + 1; i < 2 ** CFG_IDX_W; i++)
            write_reg(cfg_idx_t'(i), '1);
        send_random_angles(8);
    endtask

    task automatic test_random_sweep();
        int fl;
        for (int ph = 0; ph < 11; ph++)
        begin
            if ($urandom_range(9) == 0)
                fl = $urandom_range(1023);
            else
                fl = -int'($urandom_range(1024));
            set_config($urandom_range(2047), $urandom_range(2047), $urandom_range(2047),
                       $urandom_range(2047), fl);
            gaps_on = (ph != 5);
            send_random_angles(ph == 5 ? 150 : 45);
        end
        gaps_on = 1'b1;
    endtask

    initial
    begin
        rst_n          = 1'b0;
        start          = 1'b0;
        shoulder_angle = '0;
        elbow_angle    = '0;
        wrist_angle    = '0;
        cfg_valid      = 1'b0;
        cfg_index      = REG_SHOULDER_LEN;
        cfg_data       = '0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed_angles();
        test_keepout_edges();
        test_register_extremes();
        test_random_sweep();

        pause_for_results();
        if (pose_q.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", pose_q.size()));
        $display("checked %0d poses from %0d angle sets over %0d register settings",
                 poses_seen, items_sent, cfg_phases + 1);
        $display("angles past 359, positive floor, unused indexes and box edges included");
        if (err_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        #2ms;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
